// ===== src/pulse_width_rgb_led_controller_assert.svh =====
// Assertion macros for the pulse width RGB LED controller.
`ifndef PULSE_WIDTH_RGB_LED_CONTROLLER_ASSERT_SVH
`define PULSE_WIDTH_RGB_LED_CONTROLLER_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define PWRGB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pwrgb assertion failed");

// Next-cycle implication, clocked on clk, off during reset.
`define PWRGB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pwrgb assertion failed");

`endif

// ===== src/pwrgb_pkg.sv =====
// Shared types, constants and color tables of the pulse width RGB LED controller.
package pwrgb_pkg;

  localparam int COUNT_BITS = 16;
  localparam int PERIOD_W   = 16;
  localparam int HALF_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int LED_W      = 3;
  localparam int CIDX_W     = 3;
  localparam int BAND_STEP  = 10;
  localparam int NUM_BANDS  = 8;
  localparam int CYCLE_BAND = 9;
  localparam int NUM_COLORS = 6;

  localparam logic [PERIOD_W-1:0] STEP_PERIOD_RST = PERIOD_W'(5000);
  localparam logic [HALF_W-1:0]   HALF_WIDTH_RST  = HALF_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_PERIOD = 2'd0,
    REG_BAND_HALF   = 2'd1
  } cfg_reg_t;

  // bit0 red, bit1 green, bit2 blue
  typedef logic [LED_W-1:0] led_t;

  localparam led_t LED_OFF     = 3'b000;
  localparam led_t LED_RED     = 3'b001;
  localparam led_t LED_GREEN   = 3'b010;
  localparam led_t LED_BLUE    = 3'b100;
  localparam led_t LED_WHITE   = 3'b111;
  localparam led_t LED_YELLOW  = 3'b011;
  localparam led_t LED_MAGENTA = 3'b101;
  localparam led_t LED_CYAN    = 3'b110;

  typedef struct packed {
    logic [PERIOD_W-1:0] step_period;
    logic [HALF_W-1:0]   half_width;
  } cfg_t;

  typedef struct packed {
    logic led_hit;
    led_t leds;
    logic cycle_hit;
  } band_t;

  function automatic led_t band_leds(input logic [3:0] k);
    led_t l;
    case (k)
      4'd1:    l = LED_RED;
      4'd2:    l = LED_GREEN;
      4'd3:    l = LED_BLUE;
      4'd4:    l = LED_OFF;
      4'd5:    l = LED_WHITE;
      4'd6:    l = LED_YELLOW;
      4'd7:    l = LED_MAGENTA;
      4'd8:    l = LED_CYAN;
      default: l = LED_OFF;
    endcase
    return l;
  endfunction

  // out-of-range positions read as red
  function automatic led_t cycle_leds(input logic [CIDX_W-1:0] i);
    led_t l;
    case (i)
      3'd1:    l = LED_GREEN;
      3'd2:    l = LED_BLUE;
      3'd3:    l = LED_YELLOW;
      3'd4:    l = LED_MAGENTA;
      3'd5:    l = LED_CYAN;
      default: l = LED_RED;
    endcase
    return l;
  endfunction

endpackage

// ===== src/pwrgb_cfg.sv =====
// Configuration registers of the pulse width RGB LED controller.
module pwrgb_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic [pwrgb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pwrgb_pkg::CFG_DATA_W-1:0]   cfg_data,
  output pwrgb_pkg::cfg_t                    cfg
);
  import pwrgb_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_period <= STEP_PERIOD_RST;
      cfg_r.half_width  <= HALF_WIDTH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STEP_PERIOD: cfg_r.step_period <= cfg_data[PERIOD_W-1:0];
        REG_BAND_HALF:   cfg_r.half_width  <= cfg_data[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/pwrgb_band_dec.sv =====
// Pulse width band decoder: maps a width count to LED color and cycle-mode hit.
module pwrgb_band_dec (
  input  logic [pwrgb_pkg::COUNT_BITS-1:0] width,
  input  logic [pwrgb_pkg::HALF_W-1:0]     half_width,
  output pwrgb_pkg::band_t                 band
);
  import pwrgb_pkg::*;

  function automatic logic in_band(input logic [COUNT_BITS-1:0] w, input int k,
                                   input logic [HALF_W-1:0] h);
    logic [COUNT_BITS-1:0] c;
    c = COUNT_BITS'(BAND_STEP * k);
    return (w >= c - COUNT_BITS'(h)) && (w <= c + COUNT_BITS'(h));
  endfunction

  // later bands win when half widths make them overlap
  always_comb begin
    band = '0;
    for (int k = 1; k <= NUM_BANDS; k++) begin
      if (in_band(width, k, half_width)) begin
        band.led_hit = 1'b1;
        band.leds    = band_leds(4'(k));
      end
    end
    band.cycle_hit = in_band(width, CYCLE_BAND, half_width);
  end

endmodule

// ===== src/pulse_width_rgb_led_controller.sv =====
// Top level of the pulse width RGB LED controller: tick register, state and result register.
// A tick is held in the input register, then its result is registered into the state registers and out_valid.
// Throughput: one tick per cycle while out_ready keeps up, set by the input register and result register pair.
// A held result stalls only the stage behind it; the input register keeps accepting while free.
// Reset (synchronous, rst_n low): LEDs off, cycle mode off, counts zero, next color red,
// step_period 5000, band_half_width 2, no item in flight.
`include "pulse_width_rgb_led_controller_assert.svh"

module pulse_width_rgb_led_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_control_level,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_led_red,
  output logic                             out_led_green,
  output logic                             out_led_blue,
  output logic                             out_cycle_active,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pwrgb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pwrgb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pwrgb_pkg::*;

  localparam logic [CIDX_W-1:0] LAST_COLOR = CIDX_W'(NUM_COLORS - 1);

  cfg_t  cfg;
  band_t band;

  logic s1_valid_r, s1_level_r;
  logic out_valid_r, out_valid_nxt;
  logic adv;

  logic [COUNT_BITS-1:0] width_count_r, width_count_nxt;
  logic                  level_prev_r;
  logic                  cycle_mode_r, cycle_mode_nxt;
  logic [CIDX_W-1:0]     color_index_r, color_index_nxt;
  logic [PERIOD_W-1:0]   step_count_r, step_count_nxt;
  led_t                  led_bits_r, led_bits_nxt;

  logic [PERIOD_W-1:0]   period;
  logic [PERIOD_W:0]     step_inc;
  logic [CIDX_W-1:0]     idx;

  pwrgb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pwrgb_band_dec u_dec (
    .width      (width_count_r),
    .half_width (cfg.half_width),
    .band       (band)
  );

  assign cfg_ready = 1'b1;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // count, then decode on the falling edge, then the cycle step
  always_comb begin
    width_count_nxt = width_count_r;
    cycle_mode_nxt  = cycle_mode_r;
    color_index_nxt = color_index_r;
    step_count_nxt  = step_count_r;
    led_bits_nxt    = led_bits_r;

    period   = (cfg.step_period == '0) ? PERIOD_W'(1) : cfg.step_period;
    idx      = (color_index_r > LAST_COLOR) ? '0 : color_index_r;
    step_inc = '0;

    if (s1_level_r) begin
      if (width_count_r != '1) begin
        width_count_nxt = width_count_r + 1'b1;
      end
    end else if (level_prev_r) begin
      if (cycle_mode_r) begin
        led_bits_nxt = LED_OFF;
      end
      if (band.led_hit) begin
        led_bits_nxt = band.leds;
      end
      if (band.cycle_hit) begin
        cycle_mode_nxt = 1'b1;
        step_count_nxt = '0;
      end else begin
        cycle_mode_nxt = 1'b0;
      end
      width_count_nxt = '0;
    end

    if (cycle_mode_nxt && !s1_level_r) begin
      if (step_count_nxt == '0) begin
        led_bits_nxt    = cycle_leds(idx);
        color_index_nxt = (idx == LAST_COLOR) ? '0 : idx + 1'b1;
      end
      step_inc = {1'b0, step_count_nxt} + 1'b1;
      step_count_nxt = (step_inc >= {1'b0, period}) ? '0 : step_inc[PERIOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      width_count_r <= '0;
      level_prev_r  <= 1'b0;
      cycle_mode_r  <= 1'b0;
      color_index_r <= '0;
      step_count_r  <= '0;
      led_bits_r    <= LED_OFF;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        width_count_r <= width_count_nxt;
        level_prev_r  <= s1_level_r;
        cycle_mode_r  <= cycle_mode_nxt;
        color_index_r <= color_index_nxt;
        step_count_r  <= step_count_nxt;
        led_bits_r    <= led_bits_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_level_r <= in_control_level;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_led_red      = led_bits_r[0];
  assign out_led_green    = led_bits_r[1];
  assign out_led_blue     = led_bits_r[2];
  assign out_cycle_active = cycle_mode_r;

  // a held tick is not dropped while the result waits
  `PWRGB_ASSERT_NEXT(a_s1_hold, s1_valid_r && out_valid_r && !out_ready, s1_valid_r)
  // width only accumulates while the pin was high
  `PWRGB_ASSERT_NOW(a_width_high, width_count_r != '0, level_prev_r)
  // every falling edge clears the width count
  `PWRGB_ASSERT_NEXT(a_decode_clr, adv && !s1_level_r && level_prev_r, width_count_r == '0)
  // color position stays inside the cycle order
  `PWRGB_ASSERT_NOW(a_color_range, 1'b1, color_index_r <= LAST_COLOR)

endmodule

// ===== tb/tb_pulse_width_rgb_led_controller.sv =====
// Self-checking testbench for the pulse width RGB LED controller.
module tb_pulse_width_rgb_led_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import pwrgb_pkg::*;

  localparam int          TAIL_CYCLES  = 8;
  localparam int          LONG_HOLD    = 100;
  // ~100k ticks; worst case each tick waits out both sides' longest gaps
  localparam int unsigned CYCLE_LIMIT  = 30_000_000;
  localparam int          PHASE_PULSES = 120;
  localparam int          MAX_PRINTS   = 50;

  typedef struct packed {
    led_t leds;
    logic cycling;
  } led_state_t;

  // Tracks the LED state tick by tick and checks each returned result.
  class led_tracker;
    logic [PERIOD_W-1:0]   step_period;
    logic [HALF_W-1:0]     half_width;
    logic [COUNT_BITS-1:0] width_cnt;
    logic                  prev_level;
    logic                  cycling;
    logic [CIDX_W-1:0]     color_pos;
    int unsigned           step_cnt;
    led_t                  leds;
    led_t                  band_colors[1:8];
    led_t                  cycle_colors[6];
    led_state_t            pending_leds[$];
    int                    mismatches;
    int                    ticks;
    int                    decodes;
    int                    color_steps;
    int                    results;

    function new();
      step_period  = STEP_PERIOD_RST;
      half_width   = HALF_WIDTH_RST;
      width_cnt    = '0;
      prev_level   = 1'b0;
      cycling      = 1'b0;
      color_pos    = '0;
      step_cnt     = 0;
      leds         = LED_OFF;
      band_colors  = '{LED_RED, LED_GREEN, LED_BLUE, LED_OFF,
                       LED_WHITE, LED_YELLOW, LED_MAGENTA, LED_CYAN};
      cycle_colors = '{LED_RED, LED_GREEN, LED_BLUE, LED_YELLOW, LED_MAGENTA, LED_CYAN};
      mismatches   = 0;
      ticks        = 0;
      decodes      = 0;
      color_steps  = 0;
      results      = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_STEP_PERIOD: step_period = value[PERIOD_W-1:0];
        REG_BAND_HALF:   half_width  = value[HALF_W-1:0];
        default: ;
      endcase
    endfunction

    function bit width_in_band(int k);
      int lo;
      int hi;
      lo = BAND_STEP * k - int'(half_width);
      hi = BAND_STEP * k + int'(half_width);
      return int'(width_cnt) >= lo && int'(width_cnt) <= hi;
    endfunction

    function void note_tick(logic level);
      led_state_t        e;
      int unsigned       period;
      logic [CIDX_W-1:0] pos;
      ticks++;
      if (level) begin
        if (width_cnt != '1) width_cnt++;
      end else if (prev_level) begin
        decodes++;
        if (cycling) leds = LED_OFF;
        // later bands win
        for (int k = 1; k <= NUM_BANDS; k++) begin
          if (width_in_band(k)) leds = band_colors[k];
        end
        if (width_in_band(CYCLE_BAND)) begin
          cycling  = 1'b1;
          step_cnt = 0;
        end else begin
          cycling = 1'b0;
        end
        width_cnt = '0;
      end
      if (cycling && !level) begin
        period = (step_period == 0) ? 1 : step_period;
        if (step_cnt == 0) begin
          pos       = (color_pos > NUM_COLORS - 1) ? '0 : color_pos;
          leds      = cycle_colors[pos];
          color_pos = (pos == NUM_COLORS - 1) ? '0 : pos + 1'b1;
          color_steps++;
        end
        step_cnt++;
        if (step_cnt >= period) step_cnt = 0;
      end
      prev_level = level;
      e.leds     = leds;
      e.cycling  = cycling;
      pending_leds.push_back(e);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_leds(logic red, logic green, logic blue, logic cyc);
      led_state_t e;
      results++;
      if (pending_leds.size() == 0) begin
        report($sformatf("result %0d arrived with no tick pending", results));
        return;
      end
      e = pending_leds.pop_front();
      if (red !== e.leds[0])
        report($sformatf("result %0d red %b, want %b", results, red, e.leds[0]));
      if (green !== e.leds[1])
        report($sformatf("result %0d green %b, want %b", results, green, e.leds[1]));
      if (blue !== e.leds[2])
        report($sformatf("result %0d blue %b, want %b", results, blue, e.leds[2]));
      if (cyc !== e.cycling)
        report($sformatf("result %0d cycle_active %b, want %b", results, cyc, e.cycling));
    endtask
  endclass

  logic                  clk              = 1'b0;
  logic                  rst_n            = 1'b0;
  logic                  in_valid         = 1'b0;
  logic                  in_ready;
  logic                  in_control_level = 1'b0;
  logic                  out_valid;
  logic                  out_ready        = 1'b0;
  logic                  out_led_red;
  logic                  out_led_green;
  logic                  out_led_blue;
  logic                  out_cycle_active;
  logic                  cfg_valid        = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index        = '0;
  logic [CFG_DATA_W-1:0] cfg_data         = '0;

  led_tracker  tracker = new();
  int unsigned cycle_count     = 0;
  bit          quiet           = 1'b0;
  int          holds_requested = 0;
  int          holds_done      = 0;
  int          settings_used   = 1;
  int          cur_half        = HALF_WIDTH_RST;

  pulse_width_rgb_led_controller i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_control_level (in_control_level),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_led_red      (out_led_red),
    .out_led_green    (out_led_green),
    .out_led_blue     (out_led_blue),
    .out_cycle_active (out_cycle_active),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               tracker.pending_leds.size());
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) tracker.note_tick(in_control_level);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_leds(out_led_red, out_led_green, out_led_blue, out_cycle_active);
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  initial begin : result_sink
    int stall;
    forever begin
      if (holds_done < holds_requested) begin
        stall = LONG_HOLD;
        holds_done++;
      end else begin
        stall = quiet ? 0 : pick_gap();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_tick(input logic level);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_control_level <= level;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_pulse(input int unsigned high_ticks, input int unsigned low_ticks);
    repeat (high_ticks) send_tick(1'b1);
    repeat (low_ticks) send_tick(1'b0);
  endtask

  // sender idle until every tick has come back, then the pipeline tail
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending_leds.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last transfer
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, value);
    if (idx == REG_BAND_HALF) cur_half = value;
  endtask

  task automatic configure(input int unsigned period, input int unsigned half);
    drain();
    write_reg(REG_STEP_PERIOD, CFG_DATA_W'(period));
    write_reg(REG_BAND_HALF, CFG_DATA_W'(half));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // mostly widths near a band edge or center, some noise and glitches
  task automatic random_pulses(input int n);
    int r;
    int w;
    int lows;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 75)
        w = BAND_STEP * $urandom_range(1, CYCLE_BAND) + $urandom_range(0, 2 * cur_half + 2)
            - (cur_half + 1);
      else if (r < 90)
        w = $urandom_range(0, 100);
      else
        w = $urandom_range(1, 3);
      r = $urandom_range(0, 99);
      if (r < 5)
        lows = 0;
      else if (r < 75)
        lows = $urandom_range(1, 6);
      else
        lows = $urandom_range(7, 40);
      send_pulse(w, lows);
    end
  endtask

  initial begin : stimulus
    int directed_widths[$];
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every band with reset settings, band edges, a miss, then cycle mode
    directed_widths = '{10, 20, 30, 40, 50, 60, 70, 80, 8, 22, 13};
    foreach (directed_widths[i]) send_pulse(directed_widths[i], 1);
    send_pulse(90, 3);
    send_pulse(87, 2);   // miss while cycling: LEDs off, mode cleared
    send_pulse(90, 2);

    configure(1, 0);
    send_pulse(90, 8);   // steps every low tick, wraps the color order
    send_pulse(90, 2);   // re-entry while already cycling
    send_pulse(40, 2);   // decode while cycling
    send_pulse(91, 1);
    send_pulse(9, 1);
    send_pulse(90, 3);   // order resumes where it stopped

    configure(65535, 4);
    send_pulse(86, 3);
    send_pulse(94, 2);
    send_pulse(15, 1);
    send_pulse(6, 1);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       configure(1, 4);
        1:       configure($urandom_range(2, 9), 0);
        2:       configure(65535, $urandom_range(0, 4));
        default: configure($urandom_range(1, 20), $urandom_range(0, 4));
      endcase
      if (p == 1) begin
        random_pulses(PHASE_PULSES / 3);
        holds_requested++;   // receiver stalls while ticks keep coming
        random_pulses(PHASE_PULSES - PHASE_PULSES / 3);
      end else if (p == 2) begin
        random_pulses(PHASE_PULSES / 2);
        drain();
        random_pulses(PHASE_PULSES - PHASE_PULSES / 2);
      end else begin
        random_pulses(PHASE_PULSES);
      end
    end

    // counter saturation, enter from cycle mode, no idling
    configure(3, 2);
    quiet = 1'b1;
    send_pulse(90, 4);
    send_pulse(65540, 3);
    send_pulse(30, 2);
    quiet = 1'b0;

    drain();
    $display("%0d ticks checked over %0d register settings", tracker.ticks, settings_used);
    $display("%0d width decodes, %0d cycle color steps, long output stall and input pause hit",
             tracker.decodes, tracker.color_steps);
    if (tracker.mismatches == 0 && tracker.pending_leds.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", tracker.mismatches,
               tracker.pending_leds.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== pulse_width_rgb_led_controller.f =====
+incdir+src
src/pwrgb_pkg.sv
src/pwrgb_cfg.sv
src/pwrgb_band_dec.sv
src/pulse_width_rgb_led_controller.sv
tb/tb_pulse_width_rgb_led_controller.sv
